FILE: hw/rtl/srl_pkg.sv
// shared types and constants of the sensor record logger
package srl_pkg;

	// command codes
	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_START = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_NOT_RUNNING = 3'd1,
		STS_FULL        = 3'd2,
		STS_NO_ENTRY    = 3'd3,
		STS_NO_PERIOD   = 3'd4
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_EVAL   = 2'd1,
		ST_COMMIT = 2'd2
	} ctrl_state_t;

	// register index decoded from the word address bit
	localparam logic REG_SAMPLE_PERIOD = 1'b0;
	localparam logic [7:0] PERIOD_RESET = 8'hFF;
	localparam logic [7:0] PERIOD_UNSET_LO = 8'h00;
	localparam logic [7:0] PERIOD_UNSET_HI = 8'hFF;

	// input and record field clamps
	localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
	localparam logic signed [15:0] TEMP_MAX = 16'sd8750;
	localparam logic [15:0] HUM_MAX = 16'd10000;
	localparam logic [17:0] PRES_MIN = 18'd30000;
	localparam logic [17:0] PRES_MAX = 18'd110000;
	localparam logic [10:0] HPA_MIN = 11'd800;
	localparam logic [10:0] HPA_MAX = 11'd1200;
	localparam logic [7:0] P8_MAX = 8'd200;

	// rounding offsets
	localparam logic [13:0] HALF_STEP_50 = 14'd25;
	localparam logic [16:0] HALF_STEP_100 = 17'd50;

	// reciprocals: floor(x/50) = (x*RECIP_50) >> SHIFT_50 for x below 2^14
	localparam int SHIFT_50 = 20;
	localparam logic [14:0] RECIP_50 = 15'd20972;
	// floor(x/100) = (x*RECIP_100) >> SHIFT_100 for x below 2^17
	localparam int SHIFT_100 = 24;
	localparam logic [17:0] RECIP_100 = 18'd167773;

	// expansion constants
	localparam logic [14:0] TEMP_STEP = 15'd50;
	localparam logic [14:0] TEMP_OFFSET = 15'd4000;
	localparam logic [13:0] HUM_STEP = 14'd50;
	localparam logic [16:0] HPA_BASE = 17'd800;
	localparam logic [16:0] PA_PER_HPA = 17'd100;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    eval;
		logic    push;
		logic    start_run;
		logic    stop_run;
		logic    load_result;
		status_t status;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t action;
		logic    running;
		logic    full;
		logic    idx_ok;
		logic    period_ok;
	} dp_stat_t;

endpackage

FILE: hw/rtl/sensor_record_logger_top.sv
// top level of the sensor record logger
//
// A command beat (push, read, start or stop) is taken on the rising edge where start is
// high and busy is low. busy then stays high through ST_EVAL, for the reciprocal
// multiplies of the sample compression together with the registered read of the record
// store, and ST_COMMIT, for the store write, count update and result register load. The
// result appears in the following cycle with done high for exactly that one cycle and
// cannot be held off; busy is low by then. The sample period is written through the apb
// port at byte address 0; the user must write it only while no command is in flight,
// which the block does not enforce. Records live in a RECORD_DEPTH-entry memory with no
// clearing pass; only entries below the current count are ever returned.
module sensor_record_logger_top #(
	parameter int RECORD_DEPTH = 83
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [15:0] temp_in,
	input  logic [15:0]        humidity_in,
	input  logic [17:0]        pressure_in,
	input  logic [7:0]         read_index,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [14:0] temp_out,
	output logic [13:0]        humidity_out,
	output logic [16:0]        pressure_out,
	output logic [7:0]         record_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import srl_pkg::*;

	ctrl_cmd_t  cmd;
	dp_stat_t   stat;
	logic [7:0] sample_period;

	// configuration registers
	srl_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_period (sample_period)
	);

	// sequencer
	srl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath
	srl_dp #(
		.RECORD_DEPTH (RECORD_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sample_period (sample_period),
		.action        (action),
		.temp_in       (temp_in),
		.humidity_in   (humidity_in),
		.pressure_in   (pressure_in),
		.read_index    (read_index),
		.done          (done),
		.status        (status),
		.temp_out      (temp_out),
		.humidity_out  (humidity_out),
		.pressure_out  (pressure_out),
		.record_count  (record_count)
	);

endmodule

FILE: hw/rtl/srl_cfg.sv
// apb register block holding the sample period
module srl_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  sample_period
);
	import srl_pkg::*;

	logic [7:0] period_q;
	logic       wr_en;
	logic       sel_period;

	assign pready     = 1'b1;
	assign sel_period = (paddr[2] == REG_SAMPLE_PERIOD);
	assign wr_en      = psel && penable && pwrite && pready && sel_period;

	// sample period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (wr_en) begin
			period_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata        = sel_period ? {24'd0, period_q} : 32'd0;
	assign sample_period = period_q;

endmodule

FILE: hw/rtl/srl_ctrl.sv
// command sequencer of the sensor record logger
module srl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srl_pkg::dp_stat_t stat,
	output srl_pkg::ctrl_cmd_t cmd
);
	import srl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EVAL;
			end
			ST_EVAL:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd             = '0;
		cmd.status      = STS_OK;
		busy            = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_COMMIT: begin
				cmd.load_result = 1'b1;
				case (stat.action)
					ACT_PUSH: begin
						if (!stat.running) begin
							cmd.status = STS_NOT_RUNNING;
						end else if (stat.full) begin
							cmd.status = STS_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					ACT_READ: begin
						if (!stat.idx_ok) cmd.status = STS_NO_ENTRY;
					end
					ACT_START: begin
						if (stat.period_ok) begin
							cmd.start_run = 1'b1;
						end else begin
							cmd.status = STS_NO_PERIOD;
						end
					end
					default: begin
						cmd.stop_run = 1'b1;
					end
				endcase
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/srl_dp.sv
// datapath: sample compression, record store, count and result registers
module srl_dp #(
	parameter int RECORD_DEPTH = 83
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srl_pkg::ctrl_cmd_t cmd,
	output srl_pkg::dp_stat_t  stat,
	input  logic [7:0]         sample_period,
	input  logic [1:0]         action,
	input  logic signed [15:0] temp_in,
	input  logic [15:0]        humidity_in,
	input  logic [17:0]        pressure_in,
	input  logic [7:0]         read_index,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [14:0] temp_out,
	output logic [13:0]        humidity_out,
	output logic [16:0]        pressure_out,
	output logic [7:0]         record_count
);
	import srl_pkg::*;

	localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam logic [7:0] DEPTH_C = 8'(RECORD_DEPTH);

	// captured beat
	action_t     action_q;
	logic [7:0]  idx_q;
	logic [13:0] tx_q;
	logic [13:0] hx_q;
	logic [16:0] px_q;

	// products
	logic [28:0] t_prod_s1;
	logic [28:0] h_prod_s1;
	logic [34:0] p_prod_s1;

	// store and state
	logic [23:0] mem [RECORD_DEPTH];
	logic [23:0] rd_data_q;
	logic [7:0]  count_q;
	logic        running_q;

	// results
	logic               done_q;
	status_t            status_q;
	logic signed [14:0] temp_q;
	logic [13:0]        hum_q;
	logic [16:0]        pres_q;
	logic [7:0]         rcount_q;

	// input clamp and rounding offset
	logic signed [15:0] t_clamp;
	logic signed [16:0] t_shift;
	logic [15:0]        h_clamp;
	logic [17:0]        p_clamp;
	logic [17:0]        p_round;

	always_comb begin
		if (temp_in < TEMP_MIN) begin
			t_clamp = TEMP_MIN;
		end else if (temp_in > TEMP_MAX) begin
			t_clamp = TEMP_MAX;
		end else begin
			t_clamp = temp_in;
		end
		t_shift = 17'(t_clamp) - 17'(TEMP_MIN) + 17'(HALF_STEP_50);
		h_clamp = (humidity_in > HUM_MAX) ? HUM_MAX : humidity_in;
		if (pressure_in < PRES_MIN) begin
			p_clamp = PRES_MIN;
		end else if (pressure_in > PRES_MAX) begin
			p_clamp = PRES_MAX;
		end else begin
			p_clamp = pressure_in;
		end
		p_round = p_clamp + 18'(HALF_STEP_100);
	end

	// capture the command beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action_t'(action);
			idx_q    <= read_index;
			tx_q     <= t_shift[13:0];
			hx_q     <= h_clamp[13:0] + HALF_STEP_50;
			px_q     <= p_round[16:0];
		end
	end

	// reciprocal multiplies and store read
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			t_prod_s1 <= 29'(tx_q) * 29'(RECIP_50);
			h_prod_s1 <= 29'(hx_q) * 29'(RECIP_50);
			p_prod_s1 <= 35'(px_q) * 35'(RECIP_100);
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	// pack the record
	logic [7:0]  t8;
	logic [7:0]  rh8;
	logic [10:0] hpa;
	logic [10:0] hpa_c;
	logic [10:0] p_half;
	logic [7:0]  p8;
	logic [23:0] packed_rec;

	always_comb begin
		t8  = t_prod_s1[SHIFT_50 +: 8];
		rh8 = h_prod_s1[SHIFT_50 +: 8];
		hpa = p_prod_s1[SHIFT_100 +: 11];
		if (hpa < HPA_MIN) begin
			hpa_c = HPA_MIN;
		end else if (hpa > HPA_MAX) begin
			hpa_c = HPA_MAX;
		end else begin
			hpa_c = hpa;
		end
		p_half = hpa_c - HPA_MIN + 11'd1;
		p8     = (p_half[8:1] > P8_MAX) ? P8_MAX : p_half[8:1];
		packed_rec = {p8, rh8, t8};
	end

	// record store write
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= packed_rec;
		end
	end

	// count and running flag
	logic [7:0] count_d;

	always_comb begin
		if (cmd.push) begin
			count_d = count_q + 8'd1;
		end else if (cmd.start_run) begin
			count_d = 8'd0;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 8'd0;
			running_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.start_run) begin
				running_q <= 1'b1;
			end else if (cmd.stop_run) begin
				running_q <= 1'b0;
			end
		end
	end

	// status toward the controller
	always_comb begin
		stat.action    = action_q;
		stat.running   = running_q;
		stat.full      = (count_q >= DEPTH_C);
		stat.idx_ok    = (idx_q < count_q) && (idx_q < DEPTH_C);
		stat.period_ok = (sample_period != PERIOD_UNSET_LO) &&
			(sample_period != PERIOD_UNSET_HI);
	end

	// record expansion
	logic        read_ok;
	logic [14:0] t_exp;
	logic [13:0] h_exp;
	logic [16:0] hpa_exp;
	logic [16:0] p_exp;

	always_comb begin
		read_ok = (action_q == ACT_READ) && (cmd.status == STS_OK);
		t_exp   = 15'(rd_data_q[7:0]) * TEMP_STEP - TEMP_OFFSET;
		h_exp   = 14'(rd_data_q[15:8]) * HUM_STEP;
		hpa_exp = {8'd0, rd_data_q[23:16], 1'b0} + HPA_BASE;
		p_exp   = hpa_exp * PA_PER_HPA;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.load_result;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			status_q <= cmd.status;
			rcount_q <= count_d;
			temp_q   <= read_ok ? signed'(t_exp) : 15'sd0;
			hum_q    <= read_ok ? h_exp : 14'd0;
			pres_q   <= read_ok ? p_exp : 17'd0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign temp_out     = temp_q;
	assign humidity_out = hum_q;
	assign pressure_out = pres_q;
	assign record_count = rcount_q;

endmodule

FILE: tb/sensor_record_logger_checker.sv
// checker for the sensor record logger: predicts each result beat and compares it
module sensor_record_logger_checker #(
	parameter int RECORD_DEPTH = 83
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         action,
	input  logic signed [15:0] temp_in,
	input  logic [15:0]        humidity_in,
	input  logic [17:0]        pressure_in,
	input  logic [7:0]         read_index,
	input  logic               done,
	input  logic [2:0]         status,
	input  logic signed [14:0] temp_out,
	input  logic [13:0]        humidity_out,
	input  logic [16:0]        pressure_out,
	input  logic [7:0]         record_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output int                 mismatches,
	output int                 outstanding,
	output int                 compared
);
	timeunit 1ns;
	timeprecision 1ps;
	import srl_pkg::*;

	// one predicted result beat
	typedef struct packed {
		status_t            status;
		logic signed [14:0] temp;
		logic [13:0]        hum;
		logic [16:0]        pres;
		logic [7:0]         count;
	} log_result_t;

	// model copy of the logger state
	logic [23:0] record_mem [RECORD_DEPTH];
	logic [7:0]  count_m = '0;
	logic        running_m = 1'b0;
	logic [7:0]  period_m = PERIOD_RESET;
	log_result_t pending_results [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
		compared = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// clamp, round and pack one sample into t8 | rh8 << 8 | p8 << 16
	function automatic logic [23:0] compress_sample(input logic signed [15:0] t_raw,
			input logic [15:0] rh_raw, input logic [17:0] p_raw);
		int t, rh, p, hpa, t8, rh8, p8;
		t = t_raw;
		rh = rh_raw;
		p = p_raw;
		if (t < -4000) t = -4000;
		if (t > 8750) t = 8750;
		t8 = (t + 4000 + 25) / 50;
		if (rh > 10000) rh = 10000;
		rh8 = (rh + 25) / 50;
		if (rh8 > 200) rh8 = 200;
		if (p < 30000) p = 30000;
		if (p > 110000) p = 110000;
		hpa = (p + 50) / 100;
		if (hpa < 800) hpa = 800;
		if (hpa > 1200) hpa = 1200;
		p8 = (hpa - 800 + 1) / 2;
		if (p8 > 200) p8 = 200;
		return {8'(p8), 8'(rh8), 8'(t8)};
	endfunction

	// apply one command to the model state and work out its result
	function automatic log_result_t execute_command(input action_t act,
			input logic signed [15:0] t_raw, input logic [15:0] rh_raw,
			input logic [17:0] p_raw, input logic [7:0] idx);
		log_result_t r;
		logic [23:0] rec;
		r = '0;
		r.status = STS_OK;
		case (act)
			ACT_PUSH: begin
				if (!running_m)
					r.status = STS_NOT_RUNNING;
				else if (count_m >= RECORD_DEPTH)
					r.status = STS_FULL;
				else begin
					record_mem[count_m] = compress_sample(t_raw, rh_raw, p_raw);
					count_m = count_m + 8'd1;
				end
			end
			ACT_READ: begin
				if (idx >= count_m)
					r.status = STS_NO_ENTRY;
				else begin
					rec = record_mem[idx];
					r.temp = 15'(int'(rec[7:0]) * 50 - 4000);
					r.hum = 14'(int'(rec[15:8]) * 50);
					r.pres = 17'((int'(rec[23:16]) * 2 + 800) * 100);
				end
			end
			ACT_START: begin
				if (period_m == PERIOD_UNSET_LO || period_m == PERIOD_UNSET_HI)
					r.status = STS_NO_PERIOD;
				else begin
					count_m = '0;
					running_m = 1'b1;
				end
			end
			default: running_m = 1'b0;
		endcase
		r.count = count_m;
		return r;
	endfunction

	// watch result beats, command beats and register writes
	always @(posedge clk or negedge arst_n) begin
		log_result_t want;
		if (!arst_n) begin
			count_m = '0;
			running_m = 1'b0;
			period_m = PERIOD_RESET;
			pending_results.delete();
			outstanding = 0;
		end else begin
			// result beat against the oldest prediction
			if (done) begin
				if (pending_results.size() == 0)
					report_mismatch("result beat with no command waiting");
				else begin
					want = pending_results.pop_front();
					compared++;
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want.status));
					if (temp_out !== want.temp)
						report_mismatch($sformatf("temp_out got %0d want %0d",
							temp_out, want.temp));
					if (humidity_out !== want.hum)
						report_mismatch($sformatf("humidity_out got %0d want %0d",
							humidity_out, want.hum));
					if (pressure_out !== want.pres)
						report_mismatch($sformatf("pressure_out got %0d want %0d",
							pressure_out, want.pres));
					if (record_count !== want.count)
						report_mismatch($sformatf("record_count got %0d want %0d",
							record_count, want.count));
				end
			end
			// command beat
			if (start && !busy)
				pending_results.push_back(execute_command(action_t'(action), temp_in,
					humidity_in, pressure_in, read_index));
			// register write; only the sample period exists
			if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_PERIOD)
				period_m = pwdata[7:0];
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: tb/sensor_record_logger_top_tb.sv
// testbench top of the sensor record logger: stimulus, register writes and verdict
module sensor_record_logger_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srl_pkg::*;

	localparam int RECORD_DEPTH = 83;
	localparam int PHASES = 10;
	localparam int PHASE_CMDS = 190;
	localparam logic [2:0] ADDR_PERIOD = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         action = ACT_STOP;
	logic signed [15:0] temp_in = '0;
	logic [15:0]        humidity_in = '0;
	logic [17:0]        pressure_in = '0;
	logic [7:0]         read_index = '0;
	logic               done;
	logic [2:0]         status;
	logic signed [14:0] temp_out;
	logic [13:0]        humidity_out;
	logic [16:0]        pressure_out;
	logic [7:0]         record_count;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int mismatches;
	int outstanding;
	int compared;
	int cmd_hits [4];
	int reg_writes = 0;
	bit gaps_on = 1'b1;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sensor_record_logger_top #(
		.RECORD_DEPTH(RECORD_DEPTH)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.temp_in(temp_in), .humidity_in(humidity_in), .pressure_in(pressure_in),
		.read_index(read_index), .done(done), .status(status), .temp_out(temp_out),
		.humidity_out(humidity_out), .pressure_out(pressure_out),
		.record_count(record_count), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sensor_record_logger_checker #(
		.RECORD_DEPTH(RECORD_DEPTH)
	) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.temp_in(temp_in), .humidity_in(humidity_in), .pressure_in(pressure_in),
		.read_index(read_index), .done(done), .status(status), .temp_out(temp_out),
		.humidity_out(humidity_out), .pressure_out(pressure_out),
		.record_count(record_count), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches),
		.outstanding(outstanding), .compared(compared)
	);

	// one command beat, with a random gap once the block is free
	task automatic issue_command(input action_t act, input logic signed [15:0] t,
			input logic [15:0] h, input logic [17:0] p, input logic [7:0] idx);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(99) < 18)
			gap = $urandom_range(1, 5);
		@(negedge clk);
		while (busy) @(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		temp_in <= t;
		humidity_in <= h;
		pressure_in <= p;
		read_index <= idx;
		@(posedge clk);
		cmd_hits[act]++;
	endtask

	// stop sending and wait until every predicted result has come out
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb write: setup then access cycle
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		while (!pready) @(negedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
	endtask

	// random command, weighted toward pushes and reads
	task automatic random_command();
		action_t act;
		logic signed [15:0] t;
		logic [15:0] h;
		logic [17:0] p;
		logic [7:0] idx;
		int r;
		r = $urandom_range(99);
		if (r < 57)
			act = ACT_PUSH;
		else if (r < 87)
			act = ACT_READ;
		else if (r < 94)
			act = ACT_START;
		else
			act = ACT_STOP;
		t = ($urandom_range(9) < 2) ? 16'($urandom) : 16'($urandom_range(13000) - 4200);
		h = ($urandom_range(9) < 2) ? 16'($urandom) : 16'($urandom_range(10300));
		case ($urandom_range(9))
			0, 1: p = 18'($urandom);
			2: p = 18'($urandom_range(130000));
			default: p = 18'($urandom_range(122000, 78000));
		endcase
		idx = ($urandom_range(9) < 7) ? 8'($urandom_range(90)) : 8'($urandom);
		issue_command(act, t, h, p, idx);
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("timeout: run did not complete");
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [7:0] period;
		int w;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: error paths out of reset
		issue_command(ACT_PUSH, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_STOP, 16'sd0, 16'd0, 18'd0, 8'd0);
		drain_results();
		reg_write(ADDR_PERIOD, 32'h0000_0000);
		issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
		drain_results();
		reg_write(ADDR_PERIOD, 32'h0000_0001);
		issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
		// field extremes, clamps and rounding edges
		issue_command(ACT_PUSH, -16'sd32768, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_PUSH, 16'sd32767, 16'd65535, 18'd262143, 8'd255);
		issue_command(ACT_PUSH, -16'sd4000, 16'd10000, 18'd110000, 8'd0);
		issue_command(ACT_PUSH, 16'sd8750, 16'd9975, 18'd110001, 8'd0);
		issue_command(ACT_PUSH, -16'sd3975, 16'd24, 18'd29999, 8'd0);
		issue_command(ACT_PUSH, 16'sd8724, 16'd25, 18'd80150, 8'd0);
		issue_command(ACT_PUSH, -16'sd4001, 16'd10001, 18'd100050, 8'd0);
		// reads in range, at the count and far beyond it
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd6);
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd7);
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd255);
		// restart while running clears the count
		issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_READ, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_STOP, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_PUSH, 16'sd100, 16'd100, 18'd100000, 8'd0);
		// write to an unused register index leaves the period alone
		drain_results();
		reg_write(ADDR_UNUSED, 32'h0000_0000);
		issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
		issue_command(ACT_STOP, 16'sd0, 16'd0, 18'd0, 8'd0);

		// random phases, each under its own sample period
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: period = 8'd1;
				1: period = 8'hFF;
				2: period = 8'd0;
				3: period = 8'd254;
				default: period = 8'($urandom_range(253, 2));
			endcase
			reg_write(ADDR_PERIOD, {24'($urandom), period});
			if (ph % 3 == 2)
				reg_write(ADDR_UNUSED, $urandom);
			gaps_on = (ph != 3);
			issue_command(ACT_START, 16'sd0, 16'd0, 18'd0, 8'd0);
			for (int n = 0; n < PHASE_CMDS; n++) begin
				if (ph == 5 && n == PHASE_CMDS / 2)
					drain_results();
				random_command();
			end
		end

		// let the tail drain
		@(negedge clk);
		start <= 1'b0;
		for (w = 0; w < 2000 && outstanding != 0; w++)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("covered %0d commands: push %0d, read %0d, start %0d, stop %0d",
			cmd_hits[ACT_PUSH] + cmd_hits[ACT_READ] + cmd_hits[ACT_START] +
			cmd_hits[ACT_STOP], cmd_hits[ACT_PUSH], cmd_hits[ACT_READ],
			cmd_hits[ACT_START], cmd_hits[ACT_STOP]);
		$display("%0d result beats compared, %0d register writes, %0d results missing",
			compared, reg_writes, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/srl_pkg.sv
hw/rtl/srl_cfg.sv
hw/rtl/srl_ctrl.sv
hw/rtl/srl_dp.sv
hw/rtl/sensor_record_logger_top.sv
tb/sensor_record_logger_checker.sv
tb/sensor_record_logger_top_tb.sv
